FILE: src/sha256_pkg.sv
// Shared constants, types and round functions for the SHA-256 engine.
package sha256_pkg;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic       wr_en;      // write a byte into the block buffer
        logic [7:0] wr_data;
        logic       cnt_add;    // add eight to the bit count
        logic       fill_clr;   // restart the fill at zero
        logic       load_len;   // bytes 56..63 come from the bit count
        logic       comp_start; // copy chaining words into working words
        logic       round_en;   // run one round
        logic       comp_fold;  // add working words into chaining words
        logic       restart;    // reload initial values, clear count and fill
        logic [2:0] out_sel;
    } sha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [6:0] fill;
        logic       last_round;
    } sha_stat_t;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: src/sha256_hash_engine.sv
// Top level of the byte-serial SHA-256 hash engine.
// SHA-256 engine that takes one message byte per item and returns the
// digest as eight 32-bit words after an end-of-message item. A byte is
// accepted while the engine is idle; each 64th byte starts a compression
// that runs one round per cycle, and the input stalls until it has been
// folded in. Finishing a message pads one byte per cycle up to 56 bytes
// (up to 64 more with a second compression), runs the final compression,
// then offers the eight digest words, index 0 first.
// The input is not accepted while digest words are pending; after the
// eighth word the engine restarts from the initial hash values.
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha256_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte, .s_has_byte,
        .s_end_of_message, .m_valid, .m_ready, .m_word_index, .m_last_word,
        .cmd, .stat
    );

    sha256_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .digest_word(m_digest_word)
    );

endmodule

FILE: src/sha256_datapath.sv
// Block buffer, message schedule, round logic and chaining words.
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    output logic [31:0] digest_word
);

    logic [31:0] buf_reg [16];
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] cnt_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;

    logic [31:0] w_cur, s0, s1, t1, t2, a, e;

    assign stat.fill       = fill_reg;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign digest_word     = h_reg[cmd.out_sel];

    always_comb begin
        fill_next = fill_reg;
        if (cmd.wr_en) begin
            fill_next = fill_reg + 7'd1;
        end
        if (cmd.fill_clr || cmd.restart) begin
            fill_next = '0;
        end
    end

    // The block is held as sixteen big-endian words; a byte goes into its
    // lane of the word at the current fill, and the length fills the last two.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= cmd.wr_data;
        end
        if (cmd.load_len) begin
            buf_reg[LEN_POS[5:2]]        <= cnt_reg[63:32];
            buf_reg[LEN_POS[5:2] + 4'd1] <= cnt_reg[31:0];
        end
    end

    // Schedule: the first 16 words come from the buffer, later ones from the
    // 16-word window, which shifts every round with w_reg[0] the oldest entry.
    always_comb begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        if (rnd_reg < 6'd16) begin
            w_cur = buf_reg[rnd_reg[3:0]];
        end else begin
            w_cur = w_reg[0] + s0 + w_reg[9] + s1;
        end
        a  = v_reg[0];
        e  = v_reg[4];
        t1 = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[rnd_reg] + w_cur;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_en) begin
            for (int i = 1; i < 8; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cnt_reg  <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_HASH[i];
            end
        end else begin
            fill_reg <= fill_next;
            if (cmd.restart) begin
                cnt_reg <= '0;
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= INIT_HASH[i];
                end
            end else begin
                if (cmd.cnt_add) begin
                    cnt_reg <= cnt_reg + 64'd8;
                end
                if (cmd.comp_fold) begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
            end
            if (cmd.comp_start) begin
                rnd_reg <= '0;
            end else if (cmd.round_en) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
        end
    end

endmodule

FILE: src/sha256_ctrl.sv
// Sequencer for byte intake, padding, compression and digest output.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output logic       m_last_word,
    output sha_cmd_t   cmd,
    input  sha_stat_t  stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       eom_reg, eom_next;   // the message is being finished
    logic       pad_reg, pad_next;   // padding is underway
    logic       fin_reg, fin_next;   // the block in flight holds the length
    logic [2:0] idx_reg, idx_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        eom_next   = eom_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.out_sel = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    eom_next = s_end_of_message;
                    pad_next = 1'b0;
                    fin_next = 1'b0;
                    if (s_has_byte) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = s_data_byte;
                        cmd.cnt_add = 1'b1;
                        if (stat.fill == 7'd63) begin
                            state_next = ST_START;
                        end else if (s_end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_START: begin
                cmd.comp_start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (stat.last_round) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.comp_fold = 1'b1;
                cmd.fill_clr  = 1'b1;
                if (fin_reg) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else if (eom_reg || pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                // One pad byte a cycle: 0x80 first (eom_reg still set), then zeros.
                cmd.wr_en   = 1'b1;
                cmd.wr_data = eom_reg ? PAD_BYTE : 8'h00;
                eom_next    = 1'b0;
                pad_next    = 1'b1;
                if (stat.fill == 7'd63) begin
                    state_next = ST_START;
                end else if (stat.fill == 7'd55) begin
                    cmd.load_len = 1'b1;
                    cmd.wr_en    = 1'b1;
                    fin_next     = 1'b1;
                    state_next   = ST_START;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eom_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            eom_reg   <= eom_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_round_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |=> (state_reg == ST_ROUND))
        else $error("compression did not start");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(idx_reg)))
        else $error("digest word dropped");
`endif

endmodule
